### rtl/assert_macros.svh
// assertion helpers used by the core, clocked on clk with rst_n as the reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define CPT_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("cpt check failed");

// condition now implies consequence on the next edge
`define CPT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cpt sequence check failed");

`endif

### rtl/cpt_pkg.sv
package cpt_pkg;

    // multiplier partial product slice width
    localparam int CH = 32;

    // voronoi region of the query point
    typedef enum logic [2:0] {
        REG_A,
        REG_B,
        REG_C,
        REG_AB,
        REG_AC,
        REG_BC,
        REG_IN
    } region_t;

    // latency of cpt_mul for operand widths wa and wb
    function automatic int mul_lat(input int wa, input int wb);
        return ((wa + CH - 1) / CH) * ((wb + CH - 1) / CH) + 2;
    endfunction

endpackage

### rtl/closest_point_on_triangle_core.sv
// pipeline: 5 + 3 multiplier stages + the 36-stage restoring divider at COORD_WIDTH 32
// throughput: one beat per cycle while the skid entry is empty;
//   an output register plus one skid entry hold results
// reset: rst_n asynchronous active low clears valid bits, skid and output flags
`include "assert_macros.svh"

module closest_point_on_triangle_core import cpt_pkg::*; #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COORD_WIDTH-1:0] query_x,
    input  logic signed [COORD_WIDTH-1:0] query_y,
    input  logic signed [COORD_WIDTH-1:0] query_z,
    input  logic signed [COORD_WIDTH-1:0] corner_a_x,
    input  logic signed [COORD_WIDTH-1:0] corner_a_y,
    input  logic signed [COORD_WIDTH-1:0] corner_a_z,
    input  logic signed [COORD_WIDTH-1:0] corner_b_x,
    input  logic signed [COORD_WIDTH-1:0] corner_b_y,
    input  logic signed [COORD_WIDTH-1:0] corner_b_z,
    input  logic signed [COORD_WIDTH-1:0] corner_c_x,
    input  logic signed [COORD_WIDTH-1:0] corner_c_y,
    input  logic signed [COORD_WIDTH-1:0] corner_c_z,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [COORD_WIDTH-1:0] closest_x,
    output logic signed [COORD_WIDTH-1:0] closest_y,
    output logic signed [COORD_WIDTH-1:0] closest_z
);

    localparam int W    = COORD_WIDTH;
    localparam int DW   = W + 1;          // coordinate difference
    localparam int PW   = 2 * DW;         // difference product
    localparam int DOTW = PW + 2;         // dot product
    localparam int VPW  = 2 * DOTW;       // dot times dot
    localparam int VW   = VPW + 1;        // barycentric numerators va, vb, vc
    localparam int DENW = VW + 2;         // divisor
    localparam int NUMW = VW + DW + 1;    // dividend
    localparam int QW   = W + 2;          // quotient magnitude bits
    localparam int LM1  = mul_lat(DW, DW);
    localparam int LM2  = mul_lat(DOTW, DOTW);
    localparam int LM3  = mul_lat(VW, DW);
    localparam int LD   = QW + 2;
    localparam int N    = 5 + LM1 + LM2 + LM3 + LD;
    localparam int SW   = QW + 3;

    localparam logic signed [SW-1:0] SAT_HI = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [SW-1:0] SAT_LO = {{(SW-W+1){1'b1}}, {(W-1){1'b0}}};

    // whole pipeline advances unless the skid entry is occupied
    logic en;
    logic skid_valid_reg, skid_valid_next;
    logic vld_reg [N];

    assign en       = ~skid_valid_reg;
    assign in_ready = en;

    // ------------------------------------------------------------------
    // stage 1: edge and point-relative vectors
    // ------------------------------------------------------------------
    logic signed [W-1:0] qv [3];
    logic signed [W-1:0] av [3];
    logic signed [W-1:0] bv [3];
    logic signed [W-1:0] cv [3];

    assign qv[0] = query_x;
    assign qv[1] = query_y;
    assign qv[2] = query_z;
    assign av[0] = corner_a_x;
    assign av[1] = corner_a_y;
    assign av[2] = corner_a_z;
    assign bv[0] = corner_b_x;
    assign bv[1] = corner_b_y;
    assign bv[2] = corner_b_z;
    assign cv[0] = corner_c_x;
    assign cv[1] = corner_c_y;
    assign cv[2] = corner_c_z;

    logic [2:0][W-1:0]  a_reg, b_reg, c_reg;
    logic [2:0][DW-1:0] ab_reg, ac_reg, bc_reg, ap_reg, bp_reg, cp_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                a_reg[i]  <= av[i];
                b_reg[i]  <= bv[i];
                c_reg[i]  <= cv[i];
                ab_reg[i] <= DW'(bv[i]) - DW'(av[i]);
                ac_reg[i] <= DW'(cv[i]) - DW'(av[i]);
                bc_reg[i] <= DW'(cv[i]) - DW'(bv[i]);
                ap_reg[i] <= DW'(qv[i]) - DW'(av[i]);
                bp_reg[i] <= DW'(qv[i]) - DW'(bv[i]);
                cp_reg[i] <= DW'(qv[i]) - DW'(cv[i]);
            end
        end
    end

    // ------------------------------------------------------------------
    // dot products d1..d6: ab/ac against ap, bp, cp
    // ------------------------------------------------------------------
    logic signed [PW-1:0] dp [6][3];

    for (genvar k = 0; k < 6; k++)
    begin : g_dot
        for (genvar i = 0; i < 3; i++)
        begin : g_ax
            cpt_mul #(.WA(DW), .WB(DW)) u_mul (
                .clk (clk),
                .en  (en),
                .a   ((k % 2 == 0) ? ab_reg[i] : ac_reg[i]),
                .b   ((k / 2 == 0) ? ap_reg[i] : ((k / 2 == 1) ? bp_reg[i] : cp_reg[i])),
                .p   (dp[k][i])
            );
        end
    end

    localparam int S1W = 9 * W + 9 * DW;

    logic [S1W-1:0]     s1_out;
    logic [2:0][W-1:0]  a2, b2, c2;
    logic [2:0][DW-1:0] ab2, ac2, bc2;

    cpt_dly #(.WIDTH(S1W), .DEPTH(LM1 + 1)) u_dly_s1 (
        .clk (clk),
        .en  (en),
        .d   ({a_reg, b_reg, c_reg, ab_reg, ac_reg, bc_reg}),
        .q   (s1_out)
    );

    assign {a2, b2, c2, ab2, ac2, bc2} = s1_out;

    // stage 2: dot sums
    logic [5:0][DOTW-1:0] dot_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 6; k++)
            begin
                dot_reg[k] <= DOTW'(dp[k][0]) + DOTW'(dp[k][1]) + DOTW'(dp[k][2]);
            end
        end
    end

    // ------------------------------------------------------------------
    // cross terms: va = d3 d6 - d5 d4, vb = d5 d2 - d1 d6, vc = d1 d4 - d3 d2
    // ------------------------------------------------------------------
    logic signed [DOTW-1:0] mv_a [6];
    logic signed [DOTW-1:0] mv_b [6];
    logic signed [VPW-1:0]  mvp  [6];

    assign mv_a[0] = dot_reg[2];
    assign mv_b[0] = dot_reg[5];
    assign mv_a[1] = dot_reg[4];
    assign mv_b[1] = dot_reg[3];
    assign mv_a[2] = dot_reg[4];
    assign mv_b[2] = dot_reg[1];
    assign mv_a[3] = dot_reg[0];
    assign mv_b[3] = dot_reg[5];
    assign mv_a[4] = dot_reg[0];
    assign mv_b[4] = dot_reg[3];
    assign mv_a[5] = dot_reg[2];
    assign mv_b[5] = dot_reg[1];

    for (genvar k = 0; k < 6; k++)
    begin : g_vm
        cpt_mul #(.WA(DOTW), .WB(DOTW)) u_mul (
            .clk (clk),
            .en  (en),
            .a   (mv_a[k]),
            .b   (mv_b[k]),
            .p   (mvp[k])
        );
    end

    localparam int S2W = S1W + 6 * DOTW;

    logic [S2W-1:0]       s2_out;
    logic [2:0][W-1:0]    a3w, b3w, c3w;
    logic [2:0][DW-1:0]   ab3w, ac3w, bc3w;
    logic [5:0][DOTW-1:0] dot3w;

    cpt_dly #(.WIDTH(S2W), .DEPTH(LM2)) u_dly_s2 (
        .clk (clk),
        .en  (en),
        .d   ({a2, b2, c2, ab2, ac2, bc2, dot_reg}),
        .q   (s2_out)
    );

    assign {a3w, b3w, c3w, ab3w, ac3w, bc3w, dot3w} = s2_out;

    // stage 3: barycentric numerators and edge differences
    logic signed [VW-1:0]   va_reg, vb_reg, vc_reg;
    logic signed [DOTW:0]   dab_reg, dac_reg, w_reg, w2_reg;
    logic [5:0][DOTW-1:0]   dot3_reg;
    logic [2:0][W-1:0]      a3_reg, b3_reg, c3_reg;
    logic [2:0][DW-1:0]     ab3_reg, ac3_reg, bc3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            va_reg   <= VW'(mvp[0]) - VW'(mvp[1]);
            vb_reg   <= VW'(mvp[2]) - VW'(mvp[3]);
            vc_reg   <= VW'(mvp[4]) - VW'(mvp[5]);
            dab_reg  <= (DOTW+1)'(signed'(dot3w[0])) - (DOTW+1)'(signed'(dot3w[2]));
            dac_reg  <= (DOTW+1)'(signed'(dot3w[1])) - (DOTW+1)'(signed'(dot3w[5]));
            w_reg    <= (DOTW+1)'(signed'(dot3w[3])) - (DOTW+1)'(signed'(dot3w[2]));
            w2_reg   <= (DOTW+1)'(signed'(dot3w[4])) - (DOTW+1)'(signed'(dot3w[5]));
            dot3_reg <= dot3w;
            a3_reg   <= a3w;
            b3_reg   <= b3w;
            c3_reg   <= c3w;
            ab3_reg  <= ab3w;
            ac3_reg  <= ac3w;
            bc3_reg  <= bc3w;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: region classification and divide operand select
    // result = base + (s1 e1 + s2 e2) / den, vertex cases use 0 / 1
    // ------------------------------------------------------------------
    logic signed [DOTW-1:0] dd [6];
    logic signed [DENW-1:0] den_in;
    logic signed [DOTW+1:0] den_bc;
    region_t                region;

    for (genvar k = 0; k < 6; k++)
    begin : g_dd
        assign dd[k] = dot3_reg[k];
    end

    assign den_in = DENW'(va_reg) + DENW'(vb_reg) + DENW'(vc_reg);
    assign den_bc = (DOTW+2)'(w_reg) + (DOTW+2)'(w2_reg);

    always_comb
    begin
        if (dd[0] <= 0 && dd[1] <= 0)
        begin
            region = REG_A;
        end
        else if (dd[2] >= 0 && w_reg <= 0)
        begin
            region = REG_B;
        end
        else if (vc_reg <= 0 && dd[0] >= 0 && dd[2] <= 0)
        begin
            region = REG_AB;
        end
        else if (dd[5] >= 0 && w2_reg <= 0)
        begin
            region = REG_C;
        end
        else if (vb_reg <= 0 && dd[1] >= 0 && dd[5] <= 0)
        begin
            region = REG_AC;
        end
        else if (va_reg <= 0 && w_reg >= 0 && w2_reg >= 0)
        begin
            region = REG_BC;
        end
        else
        begin
            region = REG_IN;
        end
    end

    logic [2:0][W-1:0]    base_next, base_reg;
    logic signed [VW-1:0] s1_next, s2_next, s1_reg, s2_reg;
    logic [2:0][DW-1:0]   e1_next, e2_next, e1_reg, e2_reg;
    logic [DENW-1:0]      den_next, den_reg;

    always_comb
    begin
        base_next = a3_reg;
        s1_next   = '0;
        s2_next   = '0;
        e1_next   = '0;
        e2_next   = '0;
        den_next  = DENW'(1);
        case (region)
            REG_A:
            begin
                base_next = a3_reg;
            end
            REG_B:
            begin
                base_next = b3_reg;
            end
            REG_C:
            begin
                base_next = c3_reg;
            end
            REG_AB:
            begin
                // zero-length edge keeps corner a
                if (dab_reg > 0)
                begin
                    s1_next  = VW'(dd[0]);
                    e1_next  = ab3_reg;
                    den_next = DENW'(dab_reg);
                end
            end
            REG_AC:
            begin
                if (dac_reg > 0)
                begin
                    s1_next  = VW'(dd[1]);
                    e1_next  = ac3_reg;
                    den_next = DENW'(dac_reg);
                end
            end
            REG_BC:
            begin
                base_next = b3_reg;
                if (den_bc > 0)
                begin
                    s1_next  = VW'(w_reg);
                    e1_next  = bc3_reg;
                    den_next = DENW'(den_bc);
                end
            end
            REG_IN:
            begin
                // flat triangle falls back to corner a
                if (den_in > 0)
                begin
                    s1_next  = vb_reg;
                    e1_next  = ab3_reg;
                    s2_next  = vc_reg;
                    e2_next  = ac3_reg;
                    den_next = den_in;
                end
            end
            default:
            begin
                base_next = a3_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            base_reg <= base_next;
            s1_reg   <= s1_next;
            s2_reg   <= s2_next;
            e1_reg   <= e1_next;
            e2_reg   <= e2_next;
            den_reg  <= den_next;
        end
    end

    // ------------------------------------------------------------------
    // dividend products and stage 5 sum
    // ------------------------------------------------------------------
    logic signed [VW+DW-1:0] n1 [3];
    logic signed [VW+DW-1:0] n2 [3];
    logic signed [NUMW-1:0]  num_reg [3];

    for (genvar i = 0; i < 3; i++)
    begin : g_num
        cpt_mul #(.WA(VW), .WB(DW)) u_mul1 (
            .clk (clk),
            .en  (en),
            .a   (s1_reg),
            .b   (e1_reg[i]),
            .p   (n1[i])
        );

        cpt_mul #(.WA(VW), .WB(DW)) u_mul2 (
            .clk (clk),
            .en  (en),
            .a   (s2_reg),
            .b   (e2_reg[i]),
            .p   (n2[i])
        );

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                num_reg[i] <= NUMW'(n1[i]) + NUMW'(n2[i]);
            end
        end
    end

    logic [DENW-1:0]   den5;
    logic [2:0][W-1:0] base_o;

    cpt_dly #(.WIDTH(DENW), .DEPTH(LM3 + 1)) u_dly_den (
        .clk (clk),
        .en  (en),
        .d   (den_reg),
        .q   (den5)
    );

    cpt_dly #(.WIDTH(3 * W), .DEPTH(LM3 + 1 + LD)) u_dly_base (
        .clk (clk),
        .en  (en),
        .d   (base_reg),
        .q   (base_o)
    );

    // rounded quotient, then base add and clamp to the coordinate range
    logic signed [QW+1:0] quo [3];
    logic signed [SW-1:0] sum [3];
    logic [2:0][W-1:0]    res;

    for (genvar i = 0; i < 3; i++)
    begin : g_div
        cpt_div #(.NW(NUMW), .DNW(DENW), .QW(QW)) u_div (
            .clk (clk),
            .en  (en),
            .num (num_reg[i]),
            .den (den5),
            .quo (quo[i])
        );

        assign sum[i] = SW'(signed'(base_o[i])) + SW'(quo[i]);
        assign res[i] = (sum[i] > SAT_HI) ? W'(SAT_HI) :
                        (sum[i] < SAT_LO) ? W'(SAT_LO) : W'(sum[i]);
    end

    // valid bits travel alongside the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < N; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k < N; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // output register with one skid entry
    // ------------------------------------------------------------------
    logic              out_valid_reg, out_valid_next;
    logic [2:0][W-1:0] out_data_reg, out_data_next;
    logic [2:0][W-1:0] skid_data_reg, skid_data_next;
    logic              pipe_v;
    logic              out_stall;

    assign pipe_v    = vld_reg[N-1];
    assign out_stall = out_valid_reg && !out_ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = pipe_v;
                out_data_next  = res;
            end
        end
        else if (en && pipe_v)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid = out_valid_reg;
    assign closest_x = out_data_reg[0];
    assign closest_y = out_data_reg[1];
    assign closest_z = out_data_reg[2];

    // skid only fills behind a held output beat
    `CPT_ASSERT(a_skid_behind_out, skid_valid_reg |-> out_valid_reg)
    // a taken output beat drains the skid entry
    `CPT_ASSERT_NEXT(a_skid_drains, skid_valid_reg && out_ready, !skid_valid_reg)
    // a finished beat arriving at a stalled output is parked, not dropped
    `CPT_ASSERT_NEXT(a_skid_catches, out_stall && pipe_v && !skid_valid_reg, skid_valid_reg)

endmodule

### rtl/cpt_dly.sv
module cpt_dly #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1
) (
    input  logic             clk,
    input  logic             en,
    input  logic [WIDTH-1:0] d,
    output logic [WIDTH-1:0] q
);

    logic [WIDTH-1:0] sr_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sr_reg[0] <= d;
        end
    end

    for (genvar k = 1; k < DEPTH; k++)
    begin : g_tap
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sr_reg[k] <= sr_reg[k-1];
            end
        end
    end

    assign q = sr_reg[DEPTH-1];

endmodule

### rtl/cpt_mul.sv
module cpt_mul import cpt_pkg::*; #(
    parameter int WA = 33,
    parameter int WB = 33
) (
    input  logic                  clk,
    input  logic                  en,
    input  logic signed [WA-1:0]  a,
    input  logic signed [WB-1:0]  b,
    output logic signed [WA+WB-1:0] p
);

    localparam int NA = (WA + CH - 1) / CH;
    localparam int NB = (WB + CH - 1) / CH;
    localparam int NP = NA * NB;
    localparam int PW = WA + WB;
    localparam int AW = NA * CH;
    localparam int BW = NB * CH;

    logic [WA-1:0] abs_a;
    logic [WB-1:0] abs_b;
    logic [AW-1:0] ma_reg  [NP];
    logic [BW-1:0] mb_reg  [NP];
    logic          neg_reg [NP+1];
    logic [PW-1:0] acc_reg [NP+1];
    logic signed [PW-1:0] p_reg;

    assign abs_a = a[WA-1] ? WA'(-a) : WA'(a);
    assign abs_b = b[WB-1] ? WB'(-b) : WB'(b);

    // magnitudes and product sign
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ma_reg[0]  <= AW'(abs_a);
            mb_reg[0]  <= BW'(abs_b);
            neg_reg[0] <= a[WA-1] ^ b[WB-1];
            acc_reg[0] <= '0;
        end
    end

    // one slice product accumulated per stage
    for (genvar k = 0; k < NP; k++)
    begin : g_pp
        localparam int I = k / NB;
        localparam int J = k % NB;
        logic [2*CH-1:0]  pp;
        logic [AW+BW-1:0] sh;

        assign pp = ma_reg[k][I*CH +: CH] * mb_reg[k][J*CH +: CH];
        assign sh = (AW+BW)'(pp) << ((I + J) * CH);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                acc_reg[k+1] <= acc_reg[k] + sh[PW-1:0];
                neg_reg[k+1] <= neg_reg[k];
            end
        end

        if (k + 1 < NP)
        begin : g_fwd
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    ma_reg[k+1] <= ma_reg[k];
                    mb_reg[k+1] <= mb_reg[k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= neg_reg[NP] ? -signed'(acc_reg[NP]) : signed'(acc_reg[NP]);
        end
    end

    assign p = p_reg;

endmodule

### rtl/cpt_div.sv
module cpt_div #(
    parameter int NW  = 171,
    parameter int DNW = 139,
    parameter int QW  = 34
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [NW-1:0] num,
    input  logic [DNW-1:0]       den,
    output logic signed [QW+1:0] quo
);

    localparam int RW = (NW > DNW + QW) ? NW : DNW + QW;

    logic [NW-1:0]  abs_num;
    logic [RW-1:0]  rem_reg [QW+1];
    logic [DNW-1:0] dn_reg  [QW+1];
    logic [QW-1:0]  q_reg   [QW+1];
    logic           neg_reg [QW+1];
    logic [DNW:0]   rem2;
    logic           up;
    logic [QW:0]    qm;
    logic signed [QW+1:0] quo_reg;

    assign abs_num = num[NW-1] ? NW'(-num) : NW'(num);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= RW'(abs_num);
            dn_reg[0]  <= den;
            q_reg[0]   <= '0;
            neg_reg[0] <= num[NW-1];
        end
    end

    // restoring division, one quotient bit per stage, msb first
    for (genvar s = 0; s < QW; s++)
    begin : g_step
        localparam int K = QW - 1 - s;
        logic [RW-1:0] dsh;
        logic          ge;

        assign dsh = RW'(dn_reg[s]) << K;
        assign ge  = rem_reg[s] >= dsh;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s+1] <= ge ? rem_reg[s] - dsh : rem_reg[s];
                dn_reg[s+1]  <= dn_reg[s];
                // bit k is still clear, lower bits come later
                q_reg[s+1]   <= q_reg[s] | (QW'(ge) << K);
                neg_reg[s+1] <= neg_reg[s];
            end
        end
    end

    // round half away from zero, then restore the sign
    assign rem2 = {rem_reg[QW][DNW-1:0], 1'b0};
    assign up   = rem2 >= {1'b0, dn_reg[QW]};
    assign qm   = (QW+1)'(q_reg[QW]) + (QW+1)'(up);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quo_reg <= neg_reg[QW] ? -signed'({1'b0, qm}) : signed'({1'b0, qm});
        end
    end

    assign quo = quo_reg;

endmodule

### bench/tb_closest_point_on_triangle_core.sv
module tb_closest_point_on_triangle_core;
    timeunit 1ns;
    timeprecision 1ps;

    import cpt_pkg::*;

    localparam int CW = 32;
    localparam int ONE = 65536;       // 1.0 in q16.16
    localparam int MAX_GAP = 12;
    localparam int SHOW_LIMIT = 10;

    typedef logic signed [CW-1:0] coord_t;
    // exact intermediate math, wide enough for every dot and cross product
    typedef logic signed [319:0] wide_t;

    typedef struct {
        coord_t p[3];
        coord_t a[3];
        coord_t b[3];
        coord_t c[3];
    } tri_query_t;

    typedef struct {
        coord_t v[3];
    } point_t;

    logic   clk;
    logic   rst_n;
    logic   in_valid;
    logic   in_ready;
    coord_t query_x, query_y, query_z;
    coord_t corner_a_x, corner_a_y, corner_a_z;
    coord_t corner_b_x, corner_b_y, corner_b_z;
    coord_t corner_c_x, corner_c_y, corner_c_z;
    logic   out_valid;
    logic   out_ready;
    coord_t closest_x, closest_y, closest_z;

    point_t closest_pending[$];
    int     mismatch_count;
    bit     tx_idle_on;
    bit     rx_idle_on;
    int     rx_stall_left;

    closest_point_on_triangle_core #(
        .COORD_WIDTH(CW)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .query_x    (query_x),
        .query_y    (query_y),
        .query_z    (query_z),
        .corner_a_x (corner_a_x),
        .corner_a_y (corner_a_y),
        .corner_a_z (corner_a_z),
        .corner_b_x (corner_b_x),
        .corner_b_y (corner_b_y),
        .corner_b_z (corner_b_z),
        .corner_c_x (corner_c_x),
        .corner_c_y (corner_c_y),
        .corner_c_z (corner_c_z),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .closest_x  (closest_x),
        .closest_y  (closest_y),
        .closest_z  (closest_z)
    );

    // 12 ns clock
    initial clk = 1'b0;
    always #6 clk = ~clk;

    // ------------------------------------------------------------------
    // predictor: exact integer math, only the final coordinates rounded
    // ------------------------------------------------------------------

    // num / den rounded to nearest, ties away from zero, den > 0
    function automatic wide_t div_round(wide_t num, wide_t den);
        wide_t mag;
        wide_t quo;
        wide_t rem;
        logic  neg;
        neg = (num < 0);
        mag = neg ? -num : num;
        quo = mag / den;
        rem = mag % den;
        if ((rem <<< 1) >= den)
            quo = quo + 1;
        return neg ? -quo : quo;
    endfunction

    // clamp to the signed coordinate range
    function automatic coord_t clamp_coord(wide_t v);
        wide_t hi;
        wide_t lo;
        hi = (wide_t'(1) <<< (CW - 1)) - 1;
        lo = -(wide_t'(1) <<< (CW - 1));
        if (v > hi)
            v = hi;
        if (v < lo)
            v = lo;
        return v[CW-1:0];
    endfunction

    function automatic point_t closest_point(tri_query_t q);
        wide_t  p[3], a[3], b[3], c[3], ab[3], ac[3], bc[3], ap[3], bp[3], cp[3], res[3];
        wide_t  d1, d2, d3, d4, d5, d6, va, vb, vc, den, w;
        point_t r;
        d1 = 0; d2 = 0; d3 = 0; d4 = 0; d5 = 0; d6 = 0;
        for (int i = 0; i < 3; i++)
        begin
            p[i] = q.p[i];
            a[i] = q.a[i];
            b[i] = q.b[i];
            c[i] = q.c[i];
            ab[i] = b[i] - a[i];
            ac[i] = c[i] - a[i];
            bc[i] = c[i] - b[i];
            ap[i] = p[i] - a[i];
            bp[i] = p[i] - b[i];
            cp[i] = p[i] - c[i];
            res[i] = a[i];
            d1 += ab[i] * ap[i];
            d2 += ac[i] * ap[i];
            d3 += ab[i] * bp[i];
            d4 += ac[i] * bp[i];
            d5 += ab[i] * cp[i];
            d6 += ac[i] * cp[i];
        end
        vc = d1 * d4 - d3 * d2;
        vb = d5 * d2 - d1 * d6;
        va = d3 * d6 - d5 * d4;

        if (d1 <= 0 && d2 <= 0)
        begin
            // vertex a, res already holds a
        end
        else if (d3 >= 0 && d4 <= d3)
        begin
            for (int i = 0; i < 3; i++)
                res[i] = b[i];
        end
        else if (vc <= 0 && d1 >= 0 && d3 <= 0)
        begin
            den = d1 - d3;
            if (den > 0)
                for (int i = 0; i < 3; i++)
                    res[i] = a[i] + div_round(d1 * ab[i], den);
        end
        else if (d6 >= 0 && d5 <= d6)
        begin
            for (int i = 0; i < 3; i++)
                res[i] = c[i];
        end
        else if (vb <= 0 && d2 >= 0 && d6 <= 0)
        begin
            den = d2 - d6;
            if (den > 0)
                for (int i = 0; i < 3; i++)
                    res[i] = a[i] + div_round(d2 * ac[i], den);
        end
        else if (va <= 0 && d4 >= d3 && d5 >= d6)
        begin
            w = d4 - d3;
            den = w + (d5 - d6);
            for (int i = 0; i < 3; i++)
                res[i] = b[i];
            if (den > 0)
                for (int i = 0; i < 3; i++)
                    res[i] = b[i] + div_round(w * bc[i], den);
        end
        else
        begin
            den = va + vb + vc;
            if (den > 0)
                for (int i = 0; i < 3; i++)
                    res[i] = a[i] + div_round(ab[i] * vb + ac[i] * vc, den);
        end

        for (int i = 0; i < 3; i++)
            r.v[i] = clamp_coord(res[i]);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------

    // drive one query beat, wait for acceptance, record the expected point
    task automatic send_query(tri_query_t q);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        query_x    <= q.p[0];
        query_y    <= q.p[1];
        query_z    <= q.p[2];
        corner_a_x <= q.a[0];
        corner_a_y <= q.a[1];
        corner_a_z <= q.a[2];
        corner_b_x <= q.b[0];
        corner_b_y <= q.b[1];
        corner_b_z <= q.b[2];
        corner_c_x <= q.c[0];
        corner_c_y <= q.c[1];
        corner_c_z <= q.c[2];
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        // beat taken at this edge
        closest_pending = {closest_pending, closest_point(q)};
    endtask

    // signed random value spanning bits bits
    function automatic coord_t rand_coord(int bits);
        coord_t x;
        x = $urandom;
        return x >>> (CW - bits);
    endfunction

    function automatic tri_query_t make_query(coord_t p[3], coord_t a[3], coord_t b[3],
                                              coord_t c[3]);
        tri_query_t q;
        q.p = p;
        q.a = a;
        q.b = b;
        q.c = c;
        return q;
    endfunction

    // ------------------------------------------------------------------
    // output side
    // ------------------------------------------------------------------

    // stall draw per result, zero while the receiver runs flat out
    always @(posedge clk)
    begin
        int next_left;
        if (!rst_n)
        begin
            rx_stall_left <= 0;
            out_ready <= 1'b0;
        end
        else
        begin
            next_left = rx_stall_left;
            if (out_valid && out_ready)
                next_left = rx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
            else if (next_left > 0)
                next_left = next_left - 1;
            rx_stall_left <= next_left;
            out_ready <= (next_left == 0);
        end
    end

    // compare each result beat with the oldest expected point
    always @(posedge clk)
    begin
        point_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (closest_pending.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= SHOW_LIMIT)
                    $display("unexpected result beat (%0d, %0d, %0d) at %0t",
                             closest_x, closest_y, closest_z, $realtime);
            end
            else
            begin
                want = closest_pending.pop_front();
                if (closest_x !== want.v[0] || closest_y !== want.v[1] ||
                    closest_z !== want.v[2])
                begin
                    mismatch_count++;
                    if (mismatch_count <= SHOW_LIMIT)
                        $display("mismatch: expected (%0d, %0d, %0d) got (%0d, %0d, %0d)",
                                 want.v[0], want.v[1], want.v[2],
                                 closest_x, closest_y, closest_z);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // at least one item per region of a 4x4 right triangle, plus degenerate shapes and extremes
    task automatic test_regions_directed();
        coord_t a[3], b[3], c[3], p[3];
        coord_t z[3], hi[3], lo[3];
        a = '{0, 0, 0};
        b = '{4 * ONE, 0, 0};
        c = '{0, 4 * ONE, 0};
        // vertex a, b, c
        send_query(make_query('{-ONE, -ONE, 0}, a, b, c));
        send_query(make_query('{5 * ONE, -ONE, 0}, a, b, c));
        send_query(make_query('{-ONE, 5 * ONE, ONE}, a, b, c));
        // edges ab, ac, bc
        send_query(make_query('{2 * ONE, -ONE, 3 * ONE}, a, b, c));
        send_query(make_query('{-ONE, 2 * ONE, -2 * ONE}, a, b, c));
        send_query(make_query('{3 * ONE, 3 * ONE, 0}, a, b, c));
        // interior above the face, with a fractional split
        send_query(make_query('{ONE, ONE, 5 * ONE}, a, b, c));
        send_query(make_query('{ONE / 3, 7, -ONE}, a, b, c));
        // query on each corner
        send_query(make_query(a, a, b, c));
        send_query(make_query(b, a, b, c));
        send_query(make_query(c, a, b, c));
        // zero-length ab, zero-length ac, zero-length bc
        send_query(make_query('{ONE, ONE, ONE}, a, a, c));
        send_query(make_query('{ONE, -ONE, ONE}, a, b, a));
        send_query(make_query('{3 * ONE, 3 * ONE, ONE}, a, b, b));
        // all corners equal, collinear corners
        send_query(make_query('{ONE, 2 * ONE, 3 * ONE}, b, b, b));
        send_query(make_query('{ONE, ONE, ONE}, a, b, '{8 * ONE, 0, 0}));
        send_query(make_query('{ONE, ONE, 0}, '{-ONE, -ONE, -ONE}, '{0, 0, 0},
                              '{ONE, ONE, ONE}));
        // field extremes and saturation
        z  = '{0, 0, 0};
        hi = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff};
        lo = '{32'sh80000000, 32'sh80000000, 32'sh80000000};
        send_query(make_query(z, z, z, z));
        send_query(make_query(hi, hi, hi, hi));
        send_query(make_query(lo, lo, lo, lo));
        send_query(make_query(hi, lo, '{32'sh7fffffff, 32'sh80000000, 0},
                              '{0, 32'sh7fffffff, 32'sh80000000}));
        send_query(make_query(lo, hi, '{32'sh80000000, 32'sh7fffffff, 0},
                              '{0, 32'sh80000000, 32'sh7fffffff}));
        p = '{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff};
        send_query(make_query(p, lo, hi, '{32'sh80000000, 32'sh7fffffff, 32'sh80000000}));
    endtask

    // every field fully random, covers every bit and saturating results
    task automatic test_random_full_range(int count);
        tri_query_t q;
        for (int n = 0; n < count; n++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                q.p[i] = $urandom;
                q.a[i] = $urandom;
                q.b[i] = $urandom;
                q.c[i] = $urandom;
            end
            send_query(q);
        end
    endtask

    // triangles of random scale near an offset, query around them
    task automatic test_random_scaled(int count);
        tri_query_t q;
        coord_t     ofs[3];
        int         bits;
        for (int n = 0; n < count; n++)
        begin
            bits = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 31)
                                               : $urandom_range(4, 22);
            for (int i = 0; i < 3; i++)
            begin
                ofs[i] = rand_coord($urandom_range(1, 28));
                q.a[i] = ofs[i] + rand_coord(bits);
                q.b[i] = ofs[i] + rand_coord(bits);
                q.c[i] = ofs[i] + rand_coord(bits);
                q.p[i] = ofs[i] + rand_coord(bits + 1);
            end
            send_query(q);
        end
    endtask

    // shared, collinear or tiny corners to hit the zero divisor paths
    task automatic test_random_degenerate(int count);
        tri_query_t q;
        coord_t     d[3];
        int         kind;
        int         k;
        for (int n = 0; n < count; n++)
        begin
            kind = $urandom_range(0, 4);
            k = $urandom_range(-3, 3);
            for (int i = 0; i < 3; i++)
            begin
                q.a[i] = rand_coord(20);
                d[i]   = rand_coord(12);
                q.b[i] = q.a[i] + d[i];
                q.c[i] = q.a[i] + rand_coord(12);
                q.p[i] = q.a[i] + rand_coord(14);
                case (kind)
                    0: q.b[i] = q.a[i];
                    1: q.c[i] = q.a[i];
                    2: q.c[i] = q.b[i];
                    3: q.c[i] = q.a[i] + k * d[i];
                    default: q.a[i] = q.a[i] + rand_coord(2);
                endcase
            end
            send_query(q);
        end
    endtask

    initial
    begin
        mismatch_count = 0;
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        query_x = '0; query_y = '0; query_z = '0;
        corner_a_x = '0; corner_a_y = '0; corner_a_z = '0;
        corner_b_x = '0; corner_b_y = '0; corner_b_z = '0;
        corner_c_x = '0; corner_c_y = '0; corner_c_z = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // back to back first, then idling on both sides
        test_regions_directed();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        test_regions_directed();

        test_random_full_range(250);
        rx_idle_on = 1'b0;
        test_random_scaled(350);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b1;
        test_random_scaled(250);
        tx_idle_on = 1'b1;
        test_random_degenerate(300);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        test_random_scaled(150);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        test_random_full_range(150);

        // last beat was taken at this edge, drop valid right away
        in_valid <= 1'b0;
        while (closest_pending.size() != 0)
            @(posedge clk);
        // drain margin past the pipeline depth
        repeat (200) @(posedge clk);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // hard stop well beyond the slowest legal run
    initial
    begin
        #10ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule
